// ===== rtl/core/tvca_pkg.sv =====
// shared constants, microcode types and datapath control types for the tidal volume average
package tvca_pkg;

    // breaths held in the running average
    localparam int AVG_DEPTH = 5;

    localparam int VOL_W  = 15;
    localparam int ACC_W  = $clog2(AVG_DEPTH * 32767 + 1);
    localparam int CNT_W  = $clog2(AVG_DEPTH + 1);
    localparam int IDX_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int COEF_W = 10;

    // raw volume: flow sum / 60, saturated
    localparam int RAW_X_W     = 21;
    localparam int RAW_K       = 27;
    localparam int RAW_SAT_LIM = 32768 * 60;
    localparam int RECIP60     = ((1 << RAW_K) + 59) / 60;
    localparam int VOL_MAX     = 32767;
    localparam int VOL_FLOOR   = 10;
    localparam int MODE_OFFSET = 5;

    // tubing correction: coef * dp / 100, clamped
    localparam int DIFF_W    = 17;
    localparam int CORR_X_W  = 14;
    localparam int CORR_K    = 21;
    localparam int CORR_W    = 7;
    localparam int CORR_MAX  = 100;
    localparam int CORR_SAT  = (CORR_MAX + 1) * 100;
    localparam int RECIP100C = ((1 << CORR_K) + 99) / 100;

    // minute volume: v * rate / 100, saturated
    localparam int MV_X_W    = 23;
    localparam int MV_K      = 30;
    localparam int MV_W      = 16;
    localparam int MV_MAX    = 65535;
    localparam int MV_SAT    = (MV_MAX + 1) * 100;
    localparam int RECIP100M = ((1 << MV_K) + 99) / 100;

    // restart limit: 5 + 15 * prev / 100, taken as 3 * prev / 20
    localparam int LIM_K    = 22;
    localparam int LIM_W    = 13;
    localparam int LIM_BASE = 5;
    localparam int RECIP20  = ((1 << LIM_K) + 19) / 20;

    // average: sum / count by reciprocal, count up to 16
    localparam int AVG_K = ACC_W + 4;

    localparam int MA_W   = (ACC_W > MV_X_W) ? ACC_W : MV_X_W;
    localparam int MB_W   = (AVG_K + 1 > 24) ? AVG_K + 1 : 24;
    localparam int PROD_W = MA_W + MB_W;

    localparam logic [MB_W-1:0] AVG_RECIP [17] = '{
        MB_W'(0),
        MB_W'(((1 << AVG_K) +  0) /  1),
        MB_W'(((1 << AVG_K) +  1) /  2),
        MB_W'(((1 << AVG_K) +  2) /  3),
        MB_W'(((1 << AVG_K) +  3) /  4),
        MB_W'(((1 << AVG_K) +  4) /  5),
        MB_W'(((1 << AVG_K) +  5) /  6),
        MB_W'(((1 << AVG_K) +  6) /  7),
        MB_W'(((1 << AVG_K) +  7) /  8),
        MB_W'(((1 << AVG_K) +  8) /  9),
        MB_W'(((1 << AVG_K) +  9) / 10),
        MB_W'(((1 << AVG_K) + 10) / 11),
        MB_W'(((1 << AVG_K) + 11) / 12),
        MB_W'(((1 << AVG_K) + 12) / 13),
        MB_W'(((1 << AVG_K) + 13) / 14),
        MB_W'(((1 << AVG_K) + 14) / 15),
        MB_W'(((1 << AVG_K) + 15) / 16)
    };

    localparam int PC_W     = 4;
    localparam int PROG_LEN = 12;

    // coefficient bank order matches {pediatric, double_branch}
    typedef enum logic [1:0] {
        CFG_ADULT_SINGLE,
        CFG_ADULT_DOUBLE,
        CFG_PEDIA_SINGLE,
        CFG_PEDIA_DOUBLE
    } t_cfg_idx;

    typedef logic [3:0][COEF_W-1:0] t_coef_bank;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_RAW_MUL,
        OP_RAW_TAKE,
        OP_CORR_MUL,
        OP_CORR_TAKE,
        OP_RING,
        OP_MV_MUL,
        OP_MV_TAKE,
        OP_LIM_TAKE,
        OP_ACC,
        OP_AVG_MUL,
        OP_FINISH
    } t_op;

    typedef enum logic [1:0] {
        C_NEXT,
        C_NO_INPUT,
        C_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic load;
    } t_ctrl;

    typedef struct packed {
        logic more;
        logic out_busy;
    } t_stat;

endpackage

// ===== rtl/core/tvca_seq.sv =====
// microcode sequencer: step counter, control store and conditional jumps
module tvca_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tvca_pkg::t_stat   i_stat,
    output tvca_pkg::t_ctrl   o_ctrl
);

    localparam logic [tvca_pkg::PC_W-1:0] S_WAIT      = tvca_pkg::PC_W'(0);
    localparam logic [tvca_pkg::PC_W-1:0] S_RAW_MUL   = tvca_pkg::PC_W'(1);
    localparam logic [tvca_pkg::PC_W-1:0] S_RAW_TAKE  = tvca_pkg::PC_W'(2);
    localparam logic [tvca_pkg::PC_W-1:0] S_CORR_MUL  = tvca_pkg::PC_W'(3);
    localparam logic [tvca_pkg::PC_W-1:0] S_CORR_TAKE = tvca_pkg::PC_W'(4);
    localparam logic [tvca_pkg::PC_W-1:0] S_RING      = tvca_pkg::PC_W'(5);
    localparam logic [tvca_pkg::PC_W-1:0] S_MV_MUL    = tvca_pkg::PC_W'(6);
    localparam logic [tvca_pkg::PC_W-1:0] S_MV_TAKE   = tvca_pkg::PC_W'(7);
    localparam logic [tvca_pkg::PC_W-1:0] S_LIM_TAKE  = tvca_pkg::PC_W'(8);
    localparam logic [tvca_pkg::PC_W-1:0] S_ACC       = tvca_pkg::PC_W'(9);
    localparam logic [tvca_pkg::PC_W-1:0] S_AVG_MUL   = tvca_pkg::PC_W'(10);
    localparam logic [tvca_pkg::PC_W-1:0] S_FINISH    = tvca_pkg::PC_W'(11);
    localparam logic [tvca_pkg::PC_W-1:0] S_LAST      = tvca_pkg::PC_W'(tvca_pkg::PROG_LEN - 1);

    function automatic tvca_pkg::t_uword rom(input logic [tvca_pkg::PC_W-1:0] addr);
        tvca_pkg::t_uword w;
        case (addr)
            S_WAIT:      w = '{op: tvca_pkg::OP_LOAD, cond: tvca_pkg::C_NO_INPUT,
                               target: S_WAIT};
            S_RAW_MUL:   w = '{op: tvca_pkg::OP_RAW_MUL, cond: tvca_pkg::C_NEXT,
                               target: S_WAIT};
            S_RAW_TAKE:  w = '{op: tvca_pkg::OP_RAW_TAKE, cond: tvca_pkg::C_NEXT,
                               target: S_WAIT};
            S_CORR_MUL:  w = '{op: tvca_pkg::OP_CORR_MUL, cond: tvca_pkg::C_NEXT,
                               target: S_WAIT};
            S_CORR_TAKE: w = '{op: tvca_pkg::OP_CORR_TAKE, cond: tvca_pkg::C_NEXT,
                               target: S_WAIT};
            S_RING:      w = '{op: tvca_pkg::OP_RING, cond: tvca_pkg::C_NEXT,
                               target: S_WAIT};
            S_MV_MUL:    w = '{op: tvca_pkg::OP_MV_MUL, cond: tvca_pkg::C_NEXT,
                               target: S_WAIT};
            S_MV_TAKE:   w = '{op: tvca_pkg::OP_MV_TAKE, cond: tvca_pkg::C_NEXT,
                               target: S_WAIT};
            S_LIM_TAKE:  w = '{op: tvca_pkg::OP_LIM_TAKE, cond: tvca_pkg::C_NEXT,
                               target: S_WAIT};
            S_ACC:       w = '{op: tvca_pkg::OP_ACC, cond: tvca_pkg::C_MORE,
                               target: S_ACC};
            S_AVG_MUL:   w = '{op: tvca_pkg::OP_AVG_MUL, cond: tvca_pkg::C_NEXT,
                               target: S_WAIT};
            S_FINISH:    w = '{op: tvca_pkg::OP_FINISH, cond: tvca_pkg::C_OUT_BUSY,
                               target: S_FINISH};
            default:     w = '{op: tvca_pkg::OP_LOAD, cond: tvca_pkg::C_NEXT,
                               target: S_WAIT};
        endcase
        return w;
    endfunction

    logic [tvca_pkg::PC_W-1:0] r_pc;
    logic [tvca_pkg::PC_W-1:0] n_pc;
    tvca_pkg::t_uword          uw;
    logic                      take;

    always_comb begin
        uw = rom(r_pc);
        case (uw.cond)
            tvca_pkg::C_NEXT:     take = 1'b0;
            tvca_pkg::C_NO_INPUT: take = !i_in_valid;
            tvca_pkg::C_MORE:     take = i_stat.more;
            tvca_pkg::C_OUT_BUSY: take = i_stat.out_busy;
            default:              take = 1'b0;
        endcase
        if (take) begin
            n_pc = uw.target;
        end else if (r_pc == S_LAST) begin
            n_pc = S_WAIT;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_in_stall  = (r_pc != S_WAIT);
    assign o_ctrl.op   = uw.op;
    assign o_ctrl.load = (r_pc == S_WAIT) && i_in_valid;

endmodule

// ===== rtl/core/tvca_dp.sv =====
// datapath: breath registers, shared multiplier, volume ring, running state and result register
module tvca_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tvca_pkg::t_ctrl               i_ctrl,
    output tvca_pkg::t_stat               o_stat,
    input  tvca_pkg::t_coef_bank          i_coef,
    input  logic signed [31:0]            i_exhaled_flow_sum,
    input  logic                          i_exhaled_flow_seen,
    input  logic [14:0]                   i_peak_pressure,
    input  logic signed [15:0]            i_end_pressure,
    input  logic                          i_pediatric,
    input  logic                          i_double_branch,
    input  logic                          i_volume_or_cpap,
    input  logic [15:0]                   i_breath_rate,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [14:0]                   o_volume_average,
    output logic [15:0]                   o_minute_volume,
    output logic                          o_flow_used
);

    localparam int VW = tvca_pkg::VOL_W;

    // breath captured at transfer
    logic signed [31:0] r_flow_sum;
    logic               r_seen;
    logic [14:0]        r_pip;
    logic signed [15:0] r_pep;
    logic               r_ped;
    logic               r_dbl;
    logic               r_volcpap;
    logic [15:0]        r_rate;

    logic [tvca_pkg::PROD_W-1:0] r_prod;
    logic                        r_flag;
    logic [VW-1:0]               r_vol;
    logic [tvca_pkg::MV_W-1:0]   r_mv;
    logic [tvca_pkg::LIM_W-1:0]  r_limit;
    logic [tvca_pkg::ACC_W-1:0]  r_acc;
    logic [tvca_pkg::IDX_W-1:0]  r_ptr;
    logic [VW-1:0]               r_ring [tvca_pkg::AVG_DEPTH];

    logic [VW-1:0]               r_prev;
    logic [tvca_pkg::IDX_W-1:0]  r_idx;
    logic [tvca_pkg::CNT_W-1:0]  r_count;

    logic                        r_out_valid;
    logic [14:0]                 r_out_avg;
    logic [15:0]                 r_out_mv;
    logic                        r_out_used;

    logic                              flow_valid;
    logic                              raw_sat;
    logic signed [tvca_pkg::DIFF_W:0]  p_diff;
    logic [tvca_pkg::DIFF_W-1:0]       pos_diff;
    logic [tvca_pkg::COEF_W-1:0]       coef;
    logic [tvca_pkg::CORR_W-1:0]       corr;
    logic signed [VW+1:0]              vol_adj;
    logic [VW-1:0]                     vol_final;
    logic [VW-1:0]                     avg_q;
    logic [VW-1:0]                     vol_gap;
    logic                              restart;
    logic [VW-1:0]                     ring_rd;
    logic [tvca_pkg::CNT_W-1:0]        ptr_next;
    logic                              out_busy;
    logic [VW+1:0]                     prev3;
    logic [tvca_pkg::MA_W-1:0]         mul_a;
    logic [tvca_pkg::MB_W-1:0]         mul_b;
    logic                              mul_en;
    logic [tvca_pkg::PROD_W-1:0]       prod;

    assign flow_valid = r_seen && !r_flow_sum[31] && (|r_flow_sum[30:0]);
    assign raw_sat    = !r_flow_sum[31] && (r_flow_sum[30:0] >= 31'(tvca_pkg::RAW_SAT_LIM));

    assign p_diff   = $signed({3'b000, r_pip}) - $signed({{2{r_pep[15]}}, r_pep});
    // a falling pressure gives no correction
    assign pos_diff = (!p_diff[tvca_pkg::DIFF_W] && (p_diff != '0))
                      ? p_diff[tvca_pkg::DIFF_W-1:0] : '0;
    assign coef     = i_coef[{r_ped, r_dbl}];

    assign corr    = r_flag ? tvca_pkg::CORR_W'(tvca_pkg::CORR_MAX)
                            : r_prod[tvca_pkg::CORR_K +: tvca_pkg::CORR_W];
    assign vol_adj = $signed({2'b00, r_vol})
                   - $signed((VW+2)'(corr))
                   - (r_volcpap ? $signed((VW+2)'(0))
                                : $signed((VW+2)'(tvca_pkg::MODE_OFFSET)));
    assign vol_final = !flow_valid ? '0
                     : (vol_adj <= $signed((VW+2)'(tvca_pkg::VOL_FLOOR)))
                       ? VW'(tvca_pkg::VOL_FLOOR) : vol_adj[VW-1:0];

    assign avg_q   = r_prod[tvca_pkg::AVG_K +: VW];
    assign vol_gap = (r_vol >= r_prev) ? (r_vol - r_prev) : (r_prev - r_vol);
    assign restart = vol_gap > VW'(r_limit);

    assign ring_rd  = r_ring[r_ptr];
    assign ptr_next = tvca_pkg::CNT_W'(r_ptr) + tvca_pkg::CNT_W'(1);
    assign out_busy = r_out_valid && i_out_stall;
    assign prev3    = {2'b00, r_prev} + {1'b0, r_prev, 1'b0};

    assign o_stat.more     = ptr_next < r_count;
    assign o_stat.out_busy = out_busy;

    // one shared multiplier, product always registered before use
    always_comb begin
        mul_en = 1'b1;
        case (i_ctrl.op)
            tvca_pkg::OP_RAW_MUL: begin
                mul_a = tvca_pkg::MA_W'(r_flow_sum[tvca_pkg::RAW_X_W-1:0]);
                mul_b = tvca_pkg::MB_W'(tvca_pkg::RECIP60);
            end
            tvca_pkg::OP_RAW_TAKE: begin
                mul_a = tvca_pkg::MA_W'(pos_diff);
                mul_b = tvca_pkg::MB_W'(coef);
            end
            tvca_pkg::OP_CORR_MUL: begin
                mul_a = tvca_pkg::MA_W'(r_prod[tvca_pkg::CORR_X_W-1:0]);
                mul_b = tvca_pkg::MB_W'(tvca_pkg::RECIP100C);
            end
            tvca_pkg::OP_RING: begin
                mul_a = tvca_pkg::MA_W'(r_vol);
                mul_b = tvca_pkg::MB_W'(r_rate);
            end
            tvca_pkg::OP_MV_MUL: begin
                mul_a = tvca_pkg::MA_W'(r_prod[tvca_pkg::MV_X_W-1:0]);
                mul_b = tvca_pkg::MB_W'(tvca_pkg::RECIP100M);
            end
            tvca_pkg::OP_MV_TAKE: begin
                mul_a = tvca_pkg::MA_W'(prev3);
                mul_b = tvca_pkg::MB_W'(tvca_pkg::RECIP20);
            end
            tvca_pkg::OP_AVG_MUL: begin
                mul_a = tvca_pkg::MA_W'(r_acc);
                mul_b = tvca_pkg::AVG_RECIP[5'(r_count)];
            end
            default: begin
                mul_en = 1'b0;
                mul_a  = '0;
                mul_b  = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_flow_sum <= i_exhaled_flow_sum;
            r_seen     <= i_exhaled_flow_seen;
            r_pip      <= i_peak_pressure;
            r_pep      <= i_end_pressure;
            r_ped      <= i_pediatric;
            r_dbl      <= i_double_branch;
            r_volcpap  <= i_volume_or_cpap;
            r_rate     <= i_breath_rate;
        end
        if (mul_en) begin
            r_prod <= prod;
        end
        case (i_ctrl.op)
            tvca_pkg::OP_RAW_TAKE: begin
                r_vol <= raw_sat ? VW'(tvca_pkg::VOL_MAX) : r_prod[tvca_pkg::RAW_K +: VW];
            end
            tvca_pkg::OP_CORR_MUL: begin
                r_flag <= r_prod >= tvca_pkg::PROD_W'(tvca_pkg::CORR_SAT);
            end
            tvca_pkg::OP_CORR_TAKE: begin
                r_vol <= vol_final;
            end
            tvca_pkg::OP_RING: begin
                r_ring[r_idx] <= r_vol;
                r_acc         <= '0;
                r_ptr         <= '0;
            end
            tvca_pkg::OP_MV_MUL: begin
                r_flag <= r_prod >= tvca_pkg::PROD_W'(tvca_pkg::MV_SAT);
            end
            tvca_pkg::OP_MV_TAKE: begin
                r_mv <= r_flag ? tvca_pkg::MV_W'(tvca_pkg::MV_MAX)
                               : r_prod[tvca_pkg::MV_K +: tvca_pkg::MV_W];
            end
            tvca_pkg::OP_LIM_TAKE: begin
                r_limit <= tvca_pkg::LIM_W'(tvca_pkg::LIM_BASE)
                         + r_prod[tvca_pkg::LIM_K +: tvca_pkg::LIM_W];
            end
            tvca_pkg::OP_ACC: begin
                r_acc <= r_acc + tvca_pkg::ACC_W'(ring_rd);
                r_ptr <= r_ptr + 1'b1;
            end
            tvca_pkg::OP_FINISH: begin
                if (!out_busy) begin
                    r_out_avg  <= restart ? r_vol : avg_q;
                    r_out_mv   <= r_mv;
                    r_out_used <= flow_valid;
                end
            end
            default: begin
            end
        endcase
    end

    // ring entries past the fill count are never summed, so a restart only clears the count and the write index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result may replace one that leaves in the same cycle
            if (i_ctrl.op == tvca_pkg::OP_FINISH && !out_busy) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_ctrl.op)
                tvca_pkg::OP_RING: begin
                    if (r_count == '0) begin
                        r_prev <= r_vol;
                    end
                    r_idx <= (r_idx == tvca_pkg::IDX_W'(tvca_pkg::AVG_DEPTH - 1))
                             ? '0 : r_idx + 1'b1;
                    if (r_count != tvca_pkg::CNT_W'(tvca_pkg::AVG_DEPTH)) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                tvca_pkg::OP_FINISH: begin
                    if (!out_busy) begin
                        r_prev <= r_vol;
                        if (restart) begin
                            r_count <= '0;
                            r_idx   <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_volume_average = r_out_avg;
    assign o_minute_volume  = r_out_mv;
    assign o_flow_used      = r_out_used;

endmodule

// ===== rtl/core/tidal_volume_compensated_average_core.sv =====
// top level: coefficient registers, microcode sequencer and datapath
// Takes one breath per transfer and returns one result per breath: the
// tubing-compensated exhaled volume averaged over up to five breaths, the
// minute volume and the flow-path flag. A breath runs through a twelve-step
// microprogram that shares one multiplier for every divide-by-constant and
// adds one ring entry per cycle into the average, so a breath takes longer
// the more breaths the average currently holds. The result sits in an output
// register; a stalled result holds only the final step. Coefficient writes
// are taken at any time (ready is always high); write them only while no
// breath is in flight.
module tidal_volume_compensated_average_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [31:0]            i_exhaled_flow_sum,
    input  logic                          i_exhaled_flow_seen,
    input  logic [14:0]                   i_peak_pressure,
    input  logic signed [15:0]            i_end_pressure,
    input  logic                          i_pediatric,
    input  logic                          i_double_branch,
    input  logic                          i_volume_or_cpap,
    input  logic [15:0]                   i_breath_rate,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [14:0]                   o_volume_average,
    output logic [15:0]                   o_minute_volume,
    output logic                          o_flow_used,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [tvca_pkg::COEF_W-1:0]   i_cfg_data
);

    tvca_pkg::t_coef_bank r_coef;
    tvca_pkg::t_ctrl      ctrl;
    tvca_pkg::t_stat      stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (tvca_pkg::t_cfg_idx'(i_cfg_index))
                tvca_pkg::CFG_ADULT_SINGLE: r_coef[tvca_pkg::CFG_ADULT_SINGLE] <= i_cfg_data;
                tvca_pkg::CFG_ADULT_DOUBLE: r_coef[tvca_pkg::CFG_ADULT_DOUBLE] <= i_cfg_data;
                tvca_pkg::CFG_PEDIA_SINGLE: r_coef[tvca_pkg::CFG_PEDIA_SINGLE] <= i_cfg_data;
                tvca_pkg::CFG_PEDIA_DOUBLE: r_coef[tvca_pkg::CFG_PEDIA_DOUBLE] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tvca_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    tvca_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctrl              (ctrl),
        .o_stat              (stat),
        .i_coef              (r_coef),
        .i_exhaled_flow_sum  (i_exhaled_flow_sum),
        .i_exhaled_flow_seen (i_exhaled_flow_seen),
        .i_peak_pressure     (i_peak_pressure),
        .i_end_pressure      (i_end_pressure),
        .i_pediatric         (i_pediatric),
        .i_double_branch     (i_double_branch),
        .i_volume_or_cpap    (i_volume_or_cpap),
        .i_breath_rate       (i_breath_rate),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_volume_average    (o_volume_average),
        .o_minute_volume     (o_minute_volume),
        .o_flow_used         (o_flow_used)
    );

endmodule

// ===== rtl/core/tvca_checker.sv =====
// port-level checks on the tidal volume average core, bound to the top level
module tvca_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [14:0] o_volume_average,
    input logic [15:0] o_minute_volume,
    input logic        o_flow_used
);

    // a breath transfer always starts a busy period
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a breath transfer");

    // a fresh result coincides with the input side opening again
    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("result appeared while the sequencer was still busy");

    // no valid flow path means a zero breath volume and so zero minute volume
    a_no_flow_no_minute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_flow_used) |-> (o_minute_volume == 16'd0))
        else $error("minute volume nonzero without a valid flow path");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_volume_average)))
        else $error("stalled result changed or dropped");

endmodule

bind tidal_volume_compensated_average_core tvca_port_checks u_tvca_checker (.*);

// ===== tb/sv/tvca_checker.sv =====
// result checker for the tidal volume average core: predicts every breath and compares
module tvca_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic signed [31:0]            i_exhaled_flow_sum,
    input  logic                          i_exhaled_flow_seen,
    input  logic [14:0]                   i_peak_pressure,
    input  logic signed [15:0]            i_end_pressure,
    input  logic                          i_pediatric,
    input  logic                          i_double_branch,
    input  logic                          i_volume_or_cpap,
    input  logic [15:0]                   i_breath_rate,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [14:0]                   i_volume_average,
    input  logic [15:0]                   i_minute_volume,
    input  logic                          i_flow_used,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [tvca_pkg::COEF_W-1:0]   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint FLOW_PER_ML  = 60;
    localparam longint PERCENT      = 100;
    localparam longint CORR_LIMIT   = 100;
    localparam longint OFFSET_ML    = 5;
    localparam longint FLOOR_ML     = 10;
    localparam longint RAW_LIMIT    = 32767;
    localparam longint MINUTE_LIMIT = 65535;
    localparam longint JUMP_BASE    = 5;
    localparam longint JUMP_PCT     = 15;

    typedef struct packed {
        logic [14:0] volume_average;
        logic [15:0] minute_volume;
        logic        flow_used;
    } t_breath_result;

    logic [tvca_pkg::COEF_W-1:0] coef_bank [4];
    longint                      volume_ring [tvca_pkg::AVG_DEPTH];
    int                          ring_index;
    int                          ring_count;
    longint                      prev_volume;
    t_breath_result              expected_results [$];
    int                          fails = 0;

    // tubing-compensated volume of one breath, 0 when the flow path is not valid
    function automatic longint compensated_volume(
        input logic signed [31:0] flow_sum,
        input logic               flow_seen,
        input logic [14:0]        peak,
        input logic signed [15:0] peep,
        input logic               ped,
        input logic               dbl,
        input logic               vol_cpap
    );
        longint vol;
        longint coef;
        longint corr;
        if (!flow_seen || flow_sum <= 0) begin
            return 0;
        end
        vol = longint'(flow_sum) / FLOW_PER_ML;
        if (vol > RAW_LIMIT) begin
            vol = RAW_LIMIT;
        end
        coef = longint'(coef_bank[tvca_pkg::t_cfg_idx'({ped, dbl})]);
        // signed divide truncates toward zero, a negative pressure drop clamps to zero
        corr = (coef * (longint'(peak) - longint'(peep))) / PERCENT;
        if (corr > CORR_LIMIT) begin
            corr = CORR_LIMIT;
        end else if (corr < 0) begin
            corr = 0;
        end
        vol = vol - corr;
        if (!vol_cpap) begin
            vol = vol - OFFSET_ML;
        end
        if (vol <= FLOOR_ML) begin
            vol = FLOOR_ML;
        end
        return vol;
    endfunction

    function automatic t_breath_result predict_breath(
        input logic signed [31:0] flow_sum,
        input logic               flow_seen,
        input logic [14:0]        peak,
        input logic signed [15:0] peep,
        input logic               ped,
        input logic               dbl,
        input logic               vol_cpap,
        input logic [15:0]        rate
    );
        t_breath_result res;
        longint vol;
        longint total;
        longint avg;
        longint diff;
        longint jump_limit;
        longint minute;
        int     k;
        vol = compensated_volume(flow_sum, flow_seen, peak, peep, ped, dbl, vol_cpap);
        if (ring_count == 0) begin
            prev_volume = vol;
        end
        volume_ring[ring_index] = vol;
        ring_index = (ring_index + 1 >= tvca_pkg::AVG_DEPTH) ? 0 : ring_index + 1;
        if (ring_count < tvca_pkg::AVG_DEPTH) begin
            ring_count++;
        end
        total = 0;
        for (k = 0; k < ring_count; k++) begin
            total += volume_ring[k];
        end
        avg = total / ring_count;
        diff = vol - prev_volume;
        if (diff < 0) begin
            diff = -diff;
        end
        jump_limit = JUMP_BASE + (JUMP_PCT * prev_volume) / PERCENT;
        // a large breath-to-breath jump restarts the average
        if (diff > jump_limit) begin
            for (k = 0; k < tvca_pkg::AVG_DEPTH; k++) begin
                volume_ring[k] = 0;
            end
            ring_count = 0;
            ring_index = 0;
            avg = vol;
        end
        prev_volume = vol;
        minute = (vol * longint'(rate)) / PERCENT;
        if (minute > MINUTE_LIMIT) begin
            minute = MINUTE_LIMIT;
        end
        res.volume_average = avg[14:0];
        res.minute_volume  = minute[15:0];
        res.flow_used      = flow_seen && (flow_sum > 0);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_breath_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                coef_bank[k] = '0;
            end
            for (int k = 0; k < tvca_pkg::AVG_DEPTH; k++) begin
                volume_ring[k] = 0;
            end
            ring_index  = 0;
            ring_count  = 0;
            prev_volume = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                coef_bank[i_cfg_index] = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(predict_breath(
                    i_exhaled_flow_sum, i_exhaled_flow_seen, i_peak_pressure, i_end_pressure,
                    i_pediatric, i_double_branch, i_volume_or_cpap, i_breath_rate));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    fails++;
                    $error("result transfer with no breath pending: volume_average %0d",
                           i_volume_average);
                end else begin
                    want = expected_results.pop_front();
                    if (i_volume_average !== want.volume_average) begin
                        fails++;
                        $error("volume_average: expected %0d, actual %0d",
                               want.volume_average, i_volume_average);
                    end
                    if (i_minute_volume !== want.minute_volume) begin
                        fails++;
                        $error("minute_volume: expected %0d, actual %0d",
                               want.minute_volume, i_minute_volume);
                    end
                    if (i_flow_used !== want.flow_used) begin
                        fails++;
                        $error("flow_used: expected %0d, actual %0d",
                               want.flow_used, i_flow_used);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
    end

endmodule

// ===== tb/sv/tb_tidal_volume_compensated_average_core.sv =====
// testbench top for the tidal volume average core: breath stimulus, coefficient phases, verdict
module tb_tidal_volume_compensated_average_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES        = 7;
    localparam int PHASE_BREATHS = 100;
    localparam int COEF_TOP      = (1 << tvca_pkg::COEF_W) - 1;

    logic                          i_clk               = 1'b0;
    logic                          i_rst_n             = 1'b0;
    logic                          i_in_valid          = 1'b0;
    logic                          o_in_stall;
    logic signed [31:0]            i_exhaled_flow_sum  = '0;
    logic                          i_exhaled_flow_seen = 1'b0;
    logic [14:0]                   i_peak_pressure     = '0;
    logic signed [15:0]            i_end_pressure      = '0;
    logic                          i_pediatric         = 1'b0;
    logic                          i_double_branch     = 1'b0;
    logic                          i_volume_or_cpap    = 1'b0;
    logic [15:0]                   i_breath_rate       = '0;
    logic                          o_out_valid;
    logic                          i_out_stall         = 1'b0;
    logic [14:0]                   o_volume_average;
    logic [15:0]                   o_minute_volume;
    logic                          o_flow_used;
    logic                          i_cfg_valid         = 1'b0;
    logic                          o_cfg_ready;
    logic [1:0]                    i_cfg_index         = '0;
    logic [tvca_pkg::COEF_W-1:0]   i_cfg_data          = '0;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int stall_left  = 0;

    // current run of similar breaths
    int                 run_left = 0;
    int                 run_ml;
    logic [14:0]        run_peak;
    logic signed [15:0] run_peep;
    logic               run_ped;
    logic               run_dbl;
    logic               run_vc;

    always #4 i_clk = ~i_clk;

    tidal_volume_compensated_average_core u_top (.*);

    tvca_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_exhaled_flow_sum  (i_exhaled_flow_sum),
        .i_exhaled_flow_seen (i_exhaled_flow_seen),
        .i_peak_pressure     (i_peak_pressure),
        .i_end_pressure      (i_end_pressure),
        .i_pediatric         (i_pediatric),
        .i_double_branch     (i_double_branch),
        .i_volume_or_cpap    (i_volume_or_cpap),
        .i_breath_rate       (i_breath_rate),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_volume_average    (o_volume_average),
        .i_minute_volume     (o_minute_volume),
        .i_flow_used         (o_flow_used),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    // result-side stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || stall_pct == 0) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(1, 100) <= stall_pct) begin
            stall_left = $urandom_range(0, 9);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_breath(
        input logic signed [31:0] flow_sum,
        input logic               flow_seen,
        input logic [14:0]        peak,
        input logic signed [15:0] peep,
        input logic               ped,
        input logic               dbl,
        input logic               vol_cpap,
        input logic [15:0]        rate
    );
        int gap;
        if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_exhaled_flow_sum  <= flow_sum;
        i_exhaled_flow_seen <= flow_seen;
        i_peak_pressure     <= peak;
        i_end_pressure      <= peep;
        i_pediatric         <= ped;
        i_double_branch     <= dbl;
        i_volume_or_cpap    <= vol_cpap;
        i_breath_rate       <= rate;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop sending and wait until every breath has its result
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_coef(input tvca_pkg::t_cfg_idx idx,
                              input logic [tvca_pkg::COEF_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_coefs(input int as, input int ad, input int ps, input int pd);
        write_coef(tvca_pkg::CFG_ADULT_SINGLE, tvca_pkg::COEF_W'(as));
        write_coef(tvca_pkg::CFG_ADULT_DOUBLE, tvca_pkg::COEF_W'(ad));
        write_coef(tvca_pkg::CFG_PEDIA_SINGLE, tvca_pkg::COEF_W'(ps));
        write_coef(tvca_pkg::CFG_PEDIA_DOUBLE, tvca_pkg::COEF_W'(pd));
    endtask

    // mostly runs of similar breaths so the average fills, with noise mixed in
    task automatic random_breath();
        int                 jitter;
        logic signed [31:0] flow_sum;
        logic               flow_seen;
        if (run_left == 0) begin
            run_left = $urandom_range(2, 14);
            case ($urandom_range(0, 3))
                0: run_ml = $urandom_range(0, 40);
                1: run_ml = $urandom_range(40, 2000);
                2: run_ml = $urandom_range(2000, 32767);
                default: run_ml = $urandom_range(32768, 40000);
            endcase
            if ($urandom_range(0, 4) == 0) begin
                run_peak = 15'($urandom);
                run_peep = 16'($urandom);
            end else begin
                run_peak = 15'($urandom_range(0, 80));
                run_peep = 16'($urandom_range(0, 40));
                run_peep = run_peep - 16'sd10;
            end
            run_ped = 1'($urandom);
            run_dbl = 1'($urandom);
            run_vc  = 1'($urandom);
        end
        run_left--;
        if ($urandom_range(0, 3) == 0) begin
            send_breath($urandom, 1'($urandom), 15'($urandom), 16'($urandom),
                        1'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
        end else begin
            jitter    = $urandom_range(0, 179);
            flow_sum  = run_ml * 60 + jitter;
            flow_seen = ($urandom_range(0, 24) != 0);
            send_breath(flow_sum, flow_seen, run_peak, run_peep,
                        run_ped, run_dbl, run_vc, 16'($urandom_range(0, 65535)));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_coefs(100, 250, 1000, COEF_TOP);
        send_breath(30000, 1'b1, 15'd20, 16'sd5, 1'b0, 1'b0, 1'b1, 16'd15);
        send_breath(30120, 1'b1, 15'd20, 16'sd5, 1'b0, 1'b0, 1'b1, 16'd15);
        send_breath(30000, 1'b1, 15'd30, 16'sd5, 1'b0, 1'b1, 1'b0, 16'd20);
        send_breath(30000, 1'b1, 15'd10, 16'sd9, 1'b1, 1'b0, 1'b1, 16'd20);
        send_breath(30000, 1'b1, 15'd8, 16'sd5, 1'b1, 1'b1, 1'b0, 16'd20);
        // pressure drop below zero
        send_breath(30000, 1'b1, 15'd0, 16'sh7fff, 1'b1, 1'b1, 1'b1, 16'd20);
        // widest pressure drop, correction clamps high
        send_breath(30000, 1'b1, 15'h7fff, 16'sh8000, 1'b0, 1'b1, 1'b0, 16'd20);
        // raw volume and minute volume saturate
        send_breath(32'sh7fffffff, 1'b1, 15'd0, 16'sd0, 1'b0, 1'b0, 1'b1, 16'hffff);
        // paths that are not valid
        send_breath(32'sh80000000, 1'b1, 15'd5, 16'sd0, 1'b0, 1'b0, 1'b1, 16'd100);
        send_breath(0, 1'b1, 15'd5, 16'sd0, 1'b0, 1'b0, 1'b1, 16'd100);
        send_breath(30000, 1'b0, 15'd5, 16'sd0, 1'b0, 1'b0, 1'b1, 16'd100);
        // floor
        send_breath(600, 1'b1, 15'd0, 16'sd0, 1'b0, 1'b0, 1'b1, 16'd100);
        send_breath(959, 1'b1, 15'd0, 16'sd0, 1'b0, 1'b0, 1'b0, 16'd100);
        send_breath(720, 1'b1, 15'd0, 16'sd0, 1'b0, 1'b0, 1'b1, 16'd0);
        // steady breaths wrap the ring, then a jump restarts it
        for (int n = 0; n < 8; n++) begin
            send_breath(72000 + n * 30, 1'b1, 15'd10, 16'sd5, 1'b0, 1'b0, 1'b1, 16'd1200);
        end
        send_breath(180000, 1'b1, 15'd10, 16'sd5, 1'b0, 1'b0, 1'b1, 16'd1200);
        send_breath(180060, 1'b1, 15'd10, 16'sd5, 1'b0, 1'b0, 1'b1, 16'd1200);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: load_coefs(0, 0, 0, 0);
                1: load_coefs(COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP);
                2: load_coefs(1000, 1000, 1000, 1000);
                default: load_coefs($urandom_range(0, COEF_TOP), $urandom_range(0, COEF_TOP),
                                    $urandom_range(0, COEF_TOP), $urandom_range(0, COEF_TOP));
            endcase
            for (int n = 0; n < PHASE_BREATHS; n++) begin
                if (ph == PHASES - 1) begin
                    gap_pct = 0;
                    stall_pct <= 0;
                end else if (n % 40 == 0) begin
                    case ($urandom_range(0, 3))
                        0: gap_pct = 0;
                        1: gap_pct = 10;
                        2: gap_pct = 30;
                        default: gap_pct = 60;
                    endcase
                    case ($urandom_range(0, 3))
                        0: stall_pct <= 0;
                        1: stall_pct <= 10;
                        2: stall_pct <= 30;
                        default: stall_pct <= 60;
                    endcase
                end
                random_breath();
            end
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
